// ----- hdl/quaternion_to_euler_zyx_unit_defines.svh -----
// ------------------------------------------------------------------------
// Assertion macros for the quaternion to Euler ZYX unit
// Shared concurrent assertion forms, clocked and with or without reset.
// ------------------------------------------------------------------------
`ifndef QUATERNION_TO_EULER_ZYX_UNIT_DEFINES_SVH
`define QUATERNION_TO_EULER_ZYX_UNIT_DEFINES_SVH

// checked only while out of reset
`define QEZ_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// checked at every edge, reset included
`define QEZ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/qezyx_pkg.sv -----
// ------------------------------------------------------------------------
// qezyx_pkg
// Widths, constants and the arctangent table for the Euler angle unit.
// ------------------------------------------------------------------------
package qezyx_pkg;

    localparam int QUAT_W            = 16;
    localparam int ANGLE_W           = 16;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ATAN_LUT_LEN      = 24;
    localparam int DATA_W            = 36;  // CORDIC x/y, covers growth of 2^32 inputs
    localparam int ACC_W             = 34;  // angle accumulator, 2^32 per turn
    localparam int SQRT_STEPS        = 29;  // result bits of the pitch cosine
    localparam int RAD_W             = 58;
    localparam int T2_W              = 30;  // clamped sine, +-2^28

    localparam logic signed [ACC_W-1:0] QUARTER_TURN = ACC_W'(64'sd1073741824);

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic signed [ACC_W-1:0] atan_lut(input int idx);
        logic signed [ACC_W-1:0] v;
        case (idx)
            0:  v = ACC_W'(536870912);
            1:  v = ACC_W'(316933406);
            2:  v = ACC_W'(167458907);
            3:  v = ACC_W'(85004756);
            4:  v = ACC_W'(42667331);
            5:  v = ACC_W'(21354465);
            6:  v = ACC_W'(10679838);
            7:  v = ACC_W'(5340245);
            8:  v = ACC_W'(2670163);
            9:  v = ACC_W'(1335087);
            10: v = ACC_W'(667544);
            11: v = ACC_W'(333772);
            12: v = ACC_W'(166886);
            13: v = ACC_W'(83443);
            14: v = ACC_W'(41722);
            15: v = ACC_W'(20861);
            16: v = ACC_W'(10430);
            17: v = ACC_W'(5215);
            18: v = ACC_W'(2608);
            19: v = ACC_W'(1304);
            20: v = ACC_W'(652);
            21: v = ACC_W'(326);
            22: v = ACC_W'(163);
            23: v = ACC_W'(81);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- hdl/qezyx_cordic.sv -----
// ------------------------------------------------------------------------
// qezyx_cordic
// Pipelined vectoring CORDIC atan2, one stage per iteration, rounded and
// saturated to a 16-bit binary angle.
// ------------------------------------------------------------------------
module qezyx_cordic #(
    parameter int STAGES = qezyx_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   en,
    input  logic                                   in_valid,
    input  logic signed [qezyx_pkg::DATA_W-1:0]    in_y,
    input  logic signed [qezyx_pkg::DATA_W-1:0]    in_x,
    output logic                                   out_valid,
    output logic signed [qezyx_pkg::ANGLE_W-1:0]   out_angle
);

    localparam int DW = qezyx_pkg::DATA_W;
    localparam int AW = qezyx_pkg::ACC_W;

    logic signed [DW-1:0] x_reg   [0:STAGES];
    logic signed [DW-1:0] y_reg   [0:STAGES];
    logic signed [AW-1:0] acc_reg [0:STAGES];
    logic                 zero_reg  [0:STAGES];
    logic                 valid_reg [0:STAGES];

    logic signed [DW-1:0] x_next   [0:STAGES];
    logic signed [DW-1:0] y_next   [0:STAGES];
    logic signed [AW-1:0] acc_next [0:STAGES];

    logic signed [AW-1:0]          rnd;
    logic signed [qezyx_pkg::ANGLE_W-1:0] angle_next;
    logic signed [qezyx_pkg::ANGLE_W-1:0] out_angle_reg;
    logic                          out_valid_reg;

    // turn into the right half plane
    always_comb begin
        if (in_x < 0) begin
            if (in_y >= 0) begin
                x_next[0]   = in_y;
                y_next[0]   = -in_x;
                acc_next[0] = qezyx_pkg::QUARTER_TURN;
            end else begin
                x_next[0]   = -in_y;
                y_next[0]   = in_x;
                acc_next[0] = -qezyx_pkg::QUARTER_TURN;
            end
        end else begin
            x_next[0]   = in_x;
            y_next[0]   = in_y;
            acc_next[0] = '0;
        end
    end

    for (genvar i = 0; i < STAGES; i++) begin : g_iter
        always_comb begin
            if (y_reg[i] >= 0) begin
                x_next[i+1]   = x_reg[i] + (y_reg[i] >>> i);
                y_next[i+1]   = y_reg[i] - (x_reg[i] >>> i);
                acc_next[i+1] = acc_reg[i] + qezyx_pkg::atan_lut(i);
            end else begin
                x_next[i+1]   = x_reg[i] - (y_reg[i] >>> i);
                y_next[i+1]   = y_reg[i] + (x_reg[i] >>> i);
                acc_next[i+1] = acc_reg[i] - qezyx_pkg::atan_lut(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k <= STAGES; k++) begin
                x_reg[k]   <= x_next[k];
                y_reg[k]   <= y_next[k];
                acc_reg[k] <= acc_next[k];
            end
            zero_reg[0] <= (in_x == '0) && (in_y == '0);
            for (int k = 1; k <= STAGES; k++) begin
                zero_reg[k] <= zero_reg[k-1];
            end
        end
    end

    always_comb begin
        rnd = (acc_reg[STAGES] + AW'(32768)) >>> 16;
        if (zero_reg[STAGES]) begin
            angle_next = '0;
        end else if (rnd > AW'(32767)) begin
            angle_next = 16'sh7fff;
        end else if (rnd < -AW'(32768)) begin
            angle_next = 16'sh8000;
        end else begin
            angle_next = rnd[qezyx_pkg::ANGLE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= STAGES; k++) begin
                valid_reg[k] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg[0] <= in_valid;
            for (int k = 1; k <= STAGES; k++) begin
                valid_reg[k] <= valid_reg[k-1];
            end
            out_valid_reg <= valid_reg[STAGES];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_angle_reg <= angle_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_angle = out_angle_reg;

endmodule

// ----- hdl/quaternion_to_euler_zyx_unit.sv -----
// ------------------------------------------------------------------------
// quaternion_to_euler_zyx_unit
// Unit quaternion (Q1.14) to ZYX heading, pitch and roll binary angles.
// ------------------------------------------------------------------------
// Takes one quaternion word per cycle while no result is stalled and
// returns one angle word per word taken, in order. The pipeline registers
// products, sums and the sine square, then runs the bit-per-stage square
// root that forms the pitch cosine, one pre-rotation stage, CORDIC_STAGES
// atan2 iterations and the rounding register. The whole pipeline freezes
// while a result waits on m_tready, so s_tready is low only then.
module quaternion_to_euler_zyx_unit #(
    parameter int CORDIC_STAGES = qezyx_pkg::CORDIC_STAGES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // quat_w, quat_x, quat_y, quat_z
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // heading_angle, pitch_angle, roll_angle
);

    localparam int QW  = qezyx_pkg::QUAT_W;
    localparam int DW  = qezyx_pkg::DATA_W;
    localparam int RW  = qezyx_pkg::RAD_W;
    localparam int SQ  = qezyx_pkg::SQRT_STEPS;
    localparam int TW  = qezyx_pkg::T2_W;
    localparam int AGW = qezyx_pkg::ANGLE_W;

    logic en;

    // stage 1: products
    logic signed [2*QW-1:0] wx_reg, yz_reg, xx_reg, yy_reg, wy_reg, zx_reg;
    logic signed [2*QW-1:0] wz_reg, xy_reg, zz_reg;
    logic                   v1_reg;
    logic signed [QW-1:0]   qw, qx, qy, qz;

    // stage 2: sums
    logic signed [DW-1:0] t0_reg, t1_reg, t3_reg, t4_reg;
    logic signed [TW-1:0] t2_reg;
    logic signed [DW-1:0] t2_raw;
    logic                 v2_reg;

    // stage 3: sine squared
    logic signed [DW-1:0] t0b_reg, t1b_reg, t3b_reg, t4b_reg;
    logic signed [TW-1:0] t2b_reg;
    logic signed [2*TW-1:0] s2_full;
    logic [RW-1:0]        s2_reg;
    logic                 v3_reg;

    // square root pipeline and delay lines beside it
    logic [RW-1:0]        sv_reg   [0:SQ-1];
    logic [RW-1:0]        sr_reg   [0:SQ-1];
    logic [RW-1:0]        sv_next  [0:SQ-1];
    logic [RW-1:0]        sr_next  [0:SQ-1];
    logic signed [DW-1:0] d0_reg   [0:SQ-1];
    logic signed [DW-1:0] d1_reg   [0:SQ-1];
    logic signed [DW-1:0] d3_reg   [0:SQ-1];
    logic signed [DW-1:0] d4_reg   [0:SQ-1];
    logic signed [TW-1:0] d2_reg   [0:SQ-1];
    logic                 vs_reg   [0:SQ-1];
    logic [RW-1:0]        rad;

    logic                 roll_valid, pitch_valid, head_valid;
    logic signed [AGW-1:0] roll_angle, pitch_raw, heading_angle, pitch_angle;
    logic signed [DW-1:0] cos_x, sin_y;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    assign qw = s_tdata[15:0];
    assign qx = s_tdata[31:16];
    assign qy = s_tdata[47:32];
    assign qz = s_tdata[63:48];

    always_ff @(posedge aclk) begin
        if (en) begin
            wx_reg <= qw * qx;
            yz_reg <= qy * qz;
            xx_reg <= qx * qx;
            yy_reg <= qy * qy;
            wy_reg <= qw * qy;
            zx_reg <= qz * qx;
            wz_reg <= qw * qz;
            xy_reg <= qx * qy;
            zz_reg <= qz * qz;
        end
    end

    assign t2_raw = DW'(wy_reg) - DW'(zx_reg) <<< 1;

    always_ff @(posedge aclk) begin
        if (en) begin
            t0_reg <= (DW'(wx_reg) + DW'(yz_reg)) <<< 1;
            t1_reg <= DW'(64'sd268435456) - ((DW'(xx_reg) + DW'(yy_reg)) <<< 1);
            t3_reg <= (DW'(wz_reg) + DW'(xy_reg)) <<< 1;
            t4_reg <= DW'(64'sd268435456) - ((DW'(yy_reg) + DW'(zz_reg)) <<< 1);
            if (t2_raw > DW'(64'sd268435456)) begin
                t2_reg <= TW'(64'sd268435456);
            end else if (t2_raw < -DW'(64'sd268435456)) begin
                t2_reg <= -TW'(64'sd268435456);
            end else begin
                t2_reg <= t2_raw[TW-1:0];
            end
        end
    end

    // full-width square, at most 2^56
    assign s2_full = t2_reg * t2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            t0b_reg <= t0_reg;
            t1b_reg <= t1_reg;
            t3b_reg <= t3_reg;
            t4b_reg <= t4_reg;
            t2b_reg <= t2_reg;
            s2_reg  <= s2_full[RW-1:0];
        end
    end

    assign rad = (RW'(1) << 56) - s2_reg;

    // floor square root, one result bit per stage
    for (genvar j = 0; j < SQ; j++) begin : g_sqrt
        localparam logic [RW-1:0] BITV = RW'(1) << (56 - 2*j);
        logic [RW-1:0] v_in, r_in, trial;
        if (j == 0) begin : g_first
            assign v_in = rad;
            assign r_in = '0;
        end else begin : g_rest
            assign v_in = sv_reg[j-1];
            assign r_in = sr_reg[j-1];
        end
        assign trial = r_in + BITV;
        always_comb begin
            if (v_in >= trial) begin
                sv_next[j] = v_in - trial;
                sr_next[j] = (r_in >> 1) + BITV;
            end else begin
                sv_next[j] = v_in;
                sr_next[j] = r_in >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < SQ; k++) begin
                sv_reg[k] <= sv_next[k];
                sr_reg[k] <= sr_next[k];
            end
            d0_reg[0] <= t0b_reg;
            d1_reg[0] <= t1b_reg;
            d3_reg[0] <= t3b_reg;
            d4_reg[0] <= t4b_reg;
            d2_reg[0] <= t2b_reg;
            for (int k = 1; k < SQ; k++) begin
                d0_reg[k] <= d0_reg[k-1];
                d1_reg[k] <= d1_reg[k-1];
                d3_reg[k] <= d3_reg[k-1];
                d4_reg[k] <= d4_reg[k-1];
                d2_reg[k] <= d2_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            for (int k = 0; k < SQ; k++) begin
                vs_reg[k] <= 1'b0;
            end
        end else if (en) begin
            v1_reg    <= s_tvalid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            vs_reg[0] <= v3_reg;
            for (int k = 1; k < SQ; k++) begin
                vs_reg[k] <= vs_reg[k-1];
            end
        end
    end

    assign cos_x = DW'(sr_reg[SQ-1][SQ-1:0]);
    assign sin_y = DW'(d2_reg[SQ-1]);

    qezyx_cordic #(.STAGES(CORDIC_STAGES)) u_roll (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (vs_reg[SQ-1]),
        .in_y      (d0_reg[SQ-1]),
        .in_x      (d1_reg[SQ-1]),
        .out_valid (roll_valid),
        .out_angle (roll_angle)
    );

    qezyx_cordic #(.STAGES(CORDIC_STAGES)) u_pitch (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (vs_reg[SQ-1]),
        .in_y      (sin_y),
        .in_x      (cos_x),
        .out_valid (pitch_valid),
        .out_angle (pitch_raw)
    );

    qezyx_cordic #(.STAGES(CORDIC_STAGES)) u_head (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (vs_reg[SQ-1]),
        .in_y      (d3_reg[SQ-1]),
        .in_x      (d4_reg[SQ-1]),
        .out_valid (head_valid),
        .out_angle (heading_angle)
    );

    // pitch limited to a quarter turn either way
    always_comb begin
        if (pitch_raw > 16'sd16384) begin
            pitch_angle = 16'sd16384;
        end else if (pitch_raw < -16'sd16384) begin
            pitch_angle = -16'sd16384;
        end else begin
            pitch_angle = pitch_raw;
        end
    end

    assign m_tvalid = roll_valid & pitch_valid & head_valid;
    assign m_tdata  = {roll_angle, pitch_angle, heading_angle};

endmodule

// ----- hdl/qezyx_checker.sv -----
// ------------------------------------------------------------------------
// qezyx_checker
// Port-level checks on the Euler angle unit, bound to its top level.
// ------------------------------------------------------------------------
`include "quaternion_to_euler_zyx_unit_defines.svh"

module qezyx_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata
);

    `QEZ_ASSERT(a_hold_valid, aclk, aresetn,
        m_tvalid && !m_tready |=> m_tvalid, "result word dropped while stalled")
    `QEZ_ASSERT(a_hold_data, aclk, aresetn,
        m_tvalid && !m_tready |=> $stable(m_tdata), "result word changed while stalled")
    `QEZ_ASSERT(a_ready, aclk, aresetn,
        s_tready == (!m_tvalid || m_tready), "input ready does not follow output stall")
    `QEZ_ASSERT(a_pitch, aclk, aresetn,
        m_tvalid |-> ($signed(m_tdata[31:16]) <= 16'sd16384 &&
                      $signed(m_tdata[31:16]) >= -16'sd16384),
        "pitch beyond a quarter turn")
    `QEZ_ASSERT_ALWAYS(a_reset, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

bind quaternion_to_euler_zyx_unit qezyx_checker u_qezyx_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- tb/tb_quaternion_to_euler_zyx_unit.sv -----
// ------------------------------------------------------------------------
// tb_quaternion_to_euler_zyx_unit
// Self-checking bench for the quaternion to ZYX Euler angle unit.
// ------------------------------------------------------------------------
// Quaternion words go in through the s_ stream and angle words come out
// on the m_ stream. Every accepted input word is run through a bit-exact
// fixed-point model of the CORDIC conversion and the expected angles are
// queued. Each output word is checked against the oldest entry. Stimulus
// is a directed set of corner cases, then random unit and raw quaternions
// under three idling patterns, then a long output hold-off that fills the
// pipeline.
// ------------------------------------------------------------------------
module tb_quaternion_to_euler_zyx_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     NUM_STAGES = qezyx_pkg::CORDIC_STAGES_DEF;
    localparam longint QTURN      = 64'sd1073741824;
    localparam longint ONE_Q28    = 64'sd268435456;

    typedef struct packed {
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic signed [15:0] heading;
    } euler_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;      // quat_w, quat_x, quat_y, quat_z
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;           // heading_angle, pitch_angle, roll_angle

    euler_t      angles_pending[$];
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_cycles = 0;
    int          err_cnt = 0;
    int          words_in = 0;
    int          words_out = 0;

    longint atan_units[24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    quaternion_to_euler_zyx_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // vectoring CORDIC, returns the rounded binary angle before saturation
    function automatic longint cordic_bam(longint yv, longint xv);
        longint acc;
        longint t;
        longint xs;
        longint ys;
        acc = 0;
        if (xv == 0 && yv == 0)
            return 0;
        if (xv < 0) begin
            t = xv;
            if (yv >= 0) begin
                xv = yv; yv = -t; acc = QTURN;
            end else begin
                xv = -yv; yv = t; acc = -QTURN;
            end
        end
        for (int i = 0; i < NUM_STAGES && i < 24; i++) begin
            xs = xv >>> i;
            ys = yv >>> i;
            if (yv >= 0) begin
                xv = xv + ys; yv = yv - xs; acc = acc + atan_units[i];
            end else begin
                xv = xv - ys; yv = yv + xs; acc = acc - atan_units[i];
            end
        end
        return (acc + 32768) >>> 16;
    endfunction

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic longint sat(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic euler_t quat_to_euler(logic [63:0] word);
        longint w, x, y, z, ysq, sin_p, cos_p;
        euler_t e;
        w = longint'($signed(word[15:0]));
        x = longint'($signed(word[31:16]));
        y = longint'($signed(word[47:32]));
        z = longint'($signed(word[63:48]));
        ysq = y * y;
        e.roll = 16'(sat(cordic_bam(2 * (w * x + y * z), ONE_Q28 - 2 * (x * x + ysq)),
                         -32768, 32767));
        sin_p = sat(2 * (w * y - z * x), -ONE_Q28, ONE_Q28);
        cos_p = longint'(root_floor((64'd1 << 56) - longint'(sin_p * sin_p)));
        e.pitch = 16'(sat(cordic_bam(sin_p, cos_p), -16384, 16384));
        e.heading = 16'(sat(cordic_bam(2 * (w * z + x * y), ONE_Q28 - 2 * (ysq + z * z)),
                            -32768, 32767));
        return e;
    endfunction

    task automatic report_mismatch(string field, logic signed [15:0] got,
                                   logic signed [15:0] want);
        $display("mismatch on output word %0d: %s got %0d expected %0d",
                 words_out, field, got, want);
        err_cnt++;
    endtask

    task automatic send_quat(logic [15:0] w, logic [15:0] x,
                             logic [15:0] y, logic [15:0] z);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {z, y, x, w};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic release_input();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    // random rotation, normalised to a unit quaternion in Q1.14
    task automatic send_unit_quat();
        real c[4];
        real n;
        n = 0.0;
        foreach (c[i]) begin
            c[i] = real'(int'($urandom_range(65535)) - 32768);
            n = n + c[i] * c[i];
        end
        if (n == 0.0)
            send_quat(16'sd16384, 0, 0, 0);
        else begin
            n = $sqrt(n);
            send_quat(16'($rtoi(c[0] / n * 16384.0)), 16'($rtoi(c[1] / n * 16384.0)),
                      16'($rtoi(c[2] / n * 16384.0)), 16'($rtoi(c[3] / n * 16384.0)));
        end
    endtask

    task automatic wait_drained();
        wait (angles_pending.size() == 0);
        @(posedge aclk);
    endtask

    task automatic test_directed();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_quat(16'sd16384, 0, 0, 0);                 // identity
        send_quat(0, 0, 0, 0);                          // all-zero quaternion
        send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_quat(16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384);
        send_quat(-16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384);
        send_quat(16'sd11585, 16'sd11585, 0, 0);        // quarter turns
        send_quat(16'sd11585, 0, 16'sd11585, 0);        // gimbal lock, pitch up
        send_quat(16'sd11585, 0, -16'sd11585, 0);       // pitch down
        send_quat(16'sd11585, 0, 0, 16'sd11585);
        send_quat(16'sd16384, 0, 16'sd16384, 0);        // sine beyond one, clamped
        send_quat(16'sd16384, 0, -16'sd16384, 0);
        send_quat(0, 0, 0, 16'sd16384);                 // heading at pi, saturates
        send_quat(0, 16'sd16384, 0, 0);                 // roll at pi
        send_quat(-16'sd1, 16'sd16384, 0, 0);           // roll just above -pi
        send_quat(16'sd1, 0, 0, -16'sd16384);
        send_quat(0, 0, 16'sd16384, 0);
        send_quat(16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192);
        send_quat(16'sd100, -16'sd50, 16'sd20, 16'sd7); // far from unit length
        send_quat(16'h7fff, 16'h7fff, 16'h8000, 16'h7fff);
        send_quat(16'sd11585, 16'sd11584, 16'sd1, -16'sd1);
        release_input();
        wait_drained();
    endtask

    task automatic test_random(int n, int idle_pct, int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 75)
                send_unit_quat();
            else
                send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        end
        release_input();
        wait_drained();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        @(negedge aclk);
        hold_cycles = 400;
        for (int i = 0; i < 150; i++)
            send_unit_quat();
        release_input();
        wait_drained();
    endtask

    // result side: random stalls, or a counted hold-off
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        euler_t got, want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                angles_pending.push_back(quat_to_euler(s_tdata));
                words_in++;
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                words_out++;
                if (angles_pending.size() == 0) begin
                    $display("output word %0d arrived with nothing expected", words_out);
                    err_cnt++;
                end else begin
                    want = angles_pending.pop_front();
                    if (got.heading != want.heading)
                        report_mismatch("heading", got.heading, want.heading);
                    if (got.pitch != want.pitch)
                        report_mismatch("pitch", got.pitch, want.pitch);
                    if (got.roll != want.roll)
                        report_mismatch("roll", got.roll, want.roll);
                end
            end
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_random(500, 6, 87);
        test_random(500, 87, 6);
        test_random(500, 0, 0);
        test_backpressure();
        repeat (80) @(posedge aclk);
        $display("covered %0d quaternion words and %0d angle words: corners, random",
                 words_in, words_out);
        $display("rotations and raw words under both stall patterns and a full pipeline");
        if (err_cnt == 0 && angles_pending.size() == 0)
            $display("** quaternion_to_euler_zyx_unit: PASSED **");
        else
            $display("** quaternion_to_euler_zyx_unit: FAILED **");
        $finish;
    end

    initial begin
        #3ms;
        $display("timed out with %0d words outstanding", angles_pending.size());
        $display("** quaternion_to_euler_zyx_unit: FAILED **");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/qezyx_pkg.sv
hdl/qezyx_cordic.sv
hdl/quaternion_to_euler_zyx_unit.sv
hdl/qezyx_checker.sv
tb/tb_quaternion_to_euler_zyx_unit.sv
